// File: sv/timestamp_command_parser_assert.svh
// Assertion macros for the timestamp command parser.
// Depends on clk_i and rst_ni being visible in the including module.
`ifndef TIMESTAMP_COMMAND_PARSER_ASSERT_SVH
`define TIMESTAMP_COMMAND_PARSER_ASSERT_SVH

`ifndef NO_ASSERTIONS
// Clocked check, disabled while in reset.
`define TCP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("timestamp_command_parser: check failed");
// Same, with a caller supplied message string.
`define TCP_ASSERT_MSG(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);
`else
`define TCP_ASSERT(lbl, prop)
`define TCP_ASSERT_MSG(lbl, prop, msg)
`endif

`endif

// File: sv/tcp_pkg.sv
// Shared types, constants and helpers for the timestamp command parser.
// No dependencies.
package tcp_pkg;

  localparam int unsigned BufferLen  = 16;
  localparam int unsigned StoreDepth = BufferLen - 1;
  localparam int unsigned MinChars   = 14;
  localparam int unsigned CntW       = $clog2(BufferLen);
  localparam int unsigned IdxW       = $clog2(MinChars);

  localparam logic [7:0] StartByte = 8'h54;  // 'T'
  localparam logic [7:0] EndByte   = 8'h00;
  localparam logic [7:0] DigitZero = 8'h30;  // '0'

  // Only the first MinChars characters of a command are kept.
  typedef logic [MinChars-1:0][7:0] char_arr_t;

  typedef struct packed {
    logic            receiving;
    logic [CntW-1:0] count;
  } cap_status_t;

  typedef struct packed {
    logic [7:0] day;
    logic [7:0] month;
    logic [7:0] year;
    logic [7:0] hours;
    logic [7:0] minutes;
    logic [7:0] seconds;
  } stamp_t;

  // (hi - '0') * 10 + (lo - '0'), wrapped to 8 bits, no digit check
  function automatic logic [7:0] pair_value(input logic [7:0] hi, input logic [7:0] lo);
    logic [7:0] a;
    logic [7:0] b;
    a = hi - DigitZero;
    b = lo - DigitZero;
    return (a << 3) + (a << 1) + b;
  endfunction

endpackage

// File: sv/tcp_capture.sv
// Command capture: start/end detection, character count and character store.
// Depends on tcp_pkg.
module tcp_capture (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                fire_i,
  input  logic [7:0]          rx_data_i,
  output logic                emit_o,
  output tcp_pkg::char_arr_t  chars_o,
  output tcp_pkg::cap_status_t status_o
);

  logic                    receiving_q, receiving_d;
  logic [tcp_pkg::CntW-1:0] count_q, count_d;
  tcp_pkg::char_arr_t      store_q;
  logic                    store_we;

  always_comb begin
    receiving_d = receiving_q;
    count_d     = count_q;
    store_we    = 1'b0;
    emit_o      = 1'b0;
    if (fire_i) begin
      priority if (rx_data_i == tcp_pkg::StartByte) begin
        receiving_d = 1'b1;
        count_d     = '0;
      end else if (!receiving_q) begin
        // idle: byte dropped
      end else if (rx_data_i == tcp_pkg::EndByte) begin
        receiving_d = 1'b0;
        emit_o      = (count_q >= tcp_pkg::CntW'(tcp_pkg::MinChars));
      end else if (count_q < tcp_pkg::CntW'(tcp_pkg::StoreDepth)) begin
        store_we = (count_q < tcp_pkg::CntW'(tcp_pkg::MinChars));
        count_d  = count_q + 1'b1;
      end else begin
        // store full: abort
        receiving_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      receiving_q <= 1'b0;
      count_q     <= '0;
    end else begin
      receiving_q <= receiving_d;
      count_q     <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_q[count_q[tcp_pkg::IdxW-1:0]] <= rx_data_i;
    end
  end

  assign chars_o            = store_q;
  assign status_o.receiving = receiving_q;
  assign status_o.count     = count_q;

endmodule

// File: sv/tcp_convert.sv
// Converts the stored character pairs into date and time values.
// Depends on tcp_pkg.
module tcp_convert (
  input  tcp_pkg::char_arr_t chars_i,
  output tcp_pkg::stamp_t    stamp_o
);

  // characters 4 and 5 are skipped
  assign stamp_o.day     = tcp_pkg::pair_value(chars_i[0],  chars_i[1]);
  assign stamp_o.month   = tcp_pkg::pair_value(chars_i[2],  chars_i[3]);
  assign stamp_o.year    = tcp_pkg::pair_value(chars_i[6],  chars_i[7]);
  assign stamp_o.hours   = tcp_pkg::pair_value(chars_i[8],  chars_i[9]);
  assign stamp_o.minutes = tcp_pkg::pair_value(chars_i[10], chars_i[11]);
  assign stamp_o.seconds = tcp_pkg::pair_value(chars_i[12], chars_i[13]);

endmodule

// File: sv/timestamp_command_parser.sv
// Timestamp command parser, top level.
// Depends on tcp_pkg, tcp_capture, tcp_convert, timestamp_command_parser_assert.svh.
//
// Usage:
//   rx channel (rx_valid_i/rx_ready_o/rx_data_i) carries received UART bytes,
//   one byte per transfer. 'T' starts a command, a zero byte ends it.
//   ts channel (ts_valid_o/ts_ready_i) carries one date/time result per
//   command that held at least 14 characters when its zero byte arrived.
//   The result is registered and is on the outputs in the cycle after the end byte
//   transfer. One byte per cycle while rx_ready_o is high; the capture state and the
//   pair conversion sit between the state registers and the result register.
//   The result register decouples the sides: a byte is taken whenever the
//   result register is empty or being drained in the same cycle. If the
//   receiver stalls with a result pending, rx_ready_o drops until it is taken.
//   Reset: idle, count zero, no result pending; bytes other than 'T' are
//   dropped until a command starts.
`include "timestamp_command_parser_assert.svh"

module timestamp_command_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       rx_valid_i,
  output logic       rx_ready_o,
  input  logic [7:0] rx_data_i,
  output logic       ts_valid_o,
  input  logic       ts_ready_i,
  output logic [7:0] day_o,
  output logic [7:0] month_o,
  output logic [7:0] year_o,
  output logic [7:0] hours_o,
  output logic [7:0] minutes_o,
  output logic [7:0] seconds_o
);

  logic                  rx_fire;
  logic                  emit;
  tcp_pkg::char_arr_t    chars;
  tcp_pkg::cap_status_t  status;
  tcp_pkg::stamp_t       stamp;
  tcp_pkg::stamp_t       stamp_q;
  logic                  valid_q, valid_d;

  assign rx_ready_o = !valid_q || ts_ready_i;
  assign rx_fire    = rx_valid_i && rx_ready_o;

  tcp_capture u_capture (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .fire_i    (rx_fire),
    .rx_data_i (rx_data_i),
    .emit_o    (emit),
    .chars_o   (chars),
    .status_o  (status)
  );

  tcp_convert u_convert (
    .chars_i (chars),
    .stamp_o (stamp)
  );

  always_comb begin
    valid_d = valid_q;
    if (rx_ready_o) begin
      valid_d = rx_fire && emit;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx_fire && emit) begin
      stamp_q <= stamp;
    end
  end

  assign ts_valid_o = valid_q;
  assign day_o      = stamp_q.day;
  assign month_o    = stamp_q.month;
  assign year_o     = stamp_q.year;
  assign hours_o    = stamp_q.hours;
  assign minutes_o  = stamp_q.minutes;
  assign seconds_o  = stamp_q.seconds;

  // a new result only follows a transferred end byte
  `TCP_ASSERT(a_result_after_end,
    $rose(valid_q) |-> $past(rx_fire && rx_data_i == tcp_pkg::EndByte))
  // count never passes the store depth
  `TCP_ASSERT_MSG(a_count_bound,
    status.count <= tcp_pkg::CntW'(tcp_pkg::StoreDepth), "char count overflow")
  // start byte restarts the command
  `TCP_ASSERT(a_start_restarts,
    (rx_fire && rx_data_i == tcp_pkg::StartByte) |=>
      (status.receiving && status.count == '0))

endmodule
